### design/precondition_count_matcher_core_defines.svh
// assertion helpers shared by the matcher rtl
`ifndef PRECONDITION_COUNT_MATCHER_CORE_DEFINES_SVH
`define PRECONDITION_COUNT_MATCHER_CORE_DEFINES_SVH

// same-cycle implication
`define PCM_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define PCM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/pcm_pkg.sv
package pcm_pkg;

  localparam int NUM_VARIABLES_DEF = 256;
  localparam int NUM_FACTS_DEF     = 1024;
  localparam int NUM_OPERATORS_DEF = 1024;
  localparam int OPS_PER_FACT_DEF  = 16;
  localparam int MAX_DOMAIN_DEF    = 64;

  localparam int OP_W      = 10;
  localparam int CNT_W     = 9;
  localparam int COUNT_MAX = 511;
  localparam int EPOCH_W   = 8;

  typedef enum logic [1:0] {
    ACT_OFFSET = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_COUNT  = 2'd2,
    ACT_FACT   = 2'd3
  } action_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
  } res_t;

endpackage

### design/pcm_ram.sv
module pcm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pcm_res_fifo.sv
module pcm_res_fifo #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcm_pkg::res_t push_item,
  input  logic          pop,
  output pcm_pkg::res_t head,
  output logic          empty,
  output logic          full
);
  import pcm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (32'(count) == DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/precondition_count_matcher_core.sv
// precondition count matcher
// input channel (in_valid/in_ready) takes load items (variable offset, list
// append, precondition count) and state fact items; output channel
// (out_valid/out_ready) returns the operators whose precondition counter
// reaches zero, with last_of_run on the final one of each fact item.
// an offset or count load is written as it is taken; an append passes
// through the offset-read and append states. a fact item reads its list
// length, then walks the list: one list slot and one counter read-modify-write
// per cycle through the slot and counter memories, with forwarding between
// neighboring slots that name the same operator.
// results sit in a small queue; a new item is taken once the queue is empty,
// so a stalled receiver holds off the input side, and nothing is lost.
// reset runs a clearing pass over list lengths and touched marks before
// in_ready rises. touched marks are epoch tags; every 255 states the tags
// are swept again, which delays that one state fact by a clearing pass
// over the touched marks.
module precondition_count_matcher_core #(
  parameter int NUM_VARIABLES = pcm_pkg::NUM_VARIABLES_DEF,
  parameter int NUM_FACTS     = pcm_pkg::NUM_FACTS_DEF,
  parameter int NUM_OPERATORS = pcm_pkg::NUM_OPERATORS_DEF,
  parameter int OPS_PER_FACT  = pcm_pkg::OPS_PER_FACT_DEF,
  parameter int MAX_DOMAIN    = pcm_pkg::MAX_DOMAIN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] variable,
  input  logic [5:0] value,
  input  logic [9:0] operator_index,
  input  logic [9:0] number,
  input  logic       starts_state,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] applicable_operator,
  output logic       last_of_run,
  output logic       overflow_seen
);
  import pcm_pkg::*;

  `include "precondition_count_matcher_core_defines.svh"

  localparam int VW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam int FW = $clog2(NUM_FACTS);
  localparam int OW = (NUM_OPERATORS > 1) ? $clog2(NUM_OPERATORS) : 1;
  localparam int LW = $clog2(OPS_PER_FACT + 1);
  localparam int SD = NUM_FACTS * OPS_PER_FACT;
  localparam int SW = $clog2(SD);
  localparam int SWEEP_N = (NUM_FACTS > NUM_OPERATORS) ? NUM_FACTS : NUM_OPERATORS;
  localparam int XW = $clog2(SWEEP_N);
  localparam int RW = EPOCH_W + CNT_W;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_OFF   = 6'b000100,
    S_APP   = 6'b001000,
    S_LEN   = 6'b010000,
    S_WALK  = 6'b100000
  } state_t;

  state_t             state;
  logic               act_append;
  logic               var_ok;
  logic [5:0]         val_r;
  logic [OP_W-1:0]    op_r;
  logic [FW-1:0]      fid_r;
  logic [SW-1:0]      slot_base;
  logic [LW-1:0]      len_r;
  logic [LW-1:0]      rd_i;
  logic               a_v;
  logic               b_v;
  logic [OP_W-1:0]    b_op;
  logic               fwd_v;
  logic [OP_W-1:0]    fwd_op;
  logic [CNT_W-1:0]   fwd_cnt;
  logic               pend_v;
  logic [OP_W-1:0]    pend_op;
  logic               ovf;
  logic [EPOCH_W-1:0] epoch;
  logic [XW-1:0]      sweep_idx;
  logic               sweep_all;

  logic               acc;
  logic               off_we;
  logic [9:0]         off_q;
  logic [10:0]        fact_sum;
  logic               fact_ok;
  logic [FW-1:0]      fid;
  logic               len_we;
  logic [FW-1:0]      len_waddr;
  logic [LW-1:0]      len_wdata;
  logic               len_re;
  logic [LW-1:0]      len_q;
  logic               len_room;
  logic               slot_we;
  logic               slot_re;
  logic [OP_W-1:0]    slot_q;
  logic               o_ok;
  logic               cnt_re;
  logic               pc_we;
  logic [CNT_W-1:0]   pc_wdata;
  logic [CNT_W-1:0]   pc_q;
  logic               rem_we;
  logic [OW-1:0]      rem_waddr;
  logic [RW-1:0]      rem_wdata;
  logic [RW-1:0]      rem_q;
  logic [CNT_W-1:0]   cur;
  logic [CNT_W-1:0]   cnt_new;
  logic               touch;
  logic               dec;
  logic               res;
  logic               walk_done;
  logic               sweep_end;
  logic               fifo_push;
  res_t               fifo_item;
  res_t               fifo_head;
  logic               fifo_empty;
  logic               fifo_full;
  logic               fifo_pop;

  assign in_ready = (state == S_IDLE) && fifo_empty;
  assign acc      = in_valid && in_ready;

  // load paths
  assign off_we   = acc && (action == ACT_OFFSET) && (32'(variable) < NUM_VARIABLES);
  assign pc_we    = acc && (action == ACT_COUNT) && (32'(operator_index) < NUM_OPERATORS);
  assign pc_wdata = (32'(number) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : number[CNT_W-1:0];

  // fact id from offset and value
  assign fact_sum = {1'b0, off_q} + {5'b0, val_r};
  assign fact_ok  = var_ok && (32'(val_r) < MAX_DOMAIN) && (32'(fact_sum) < NUM_FACTS);
  assign fid      = FW'(fact_sum);
  assign len_re   = (state == S_OFF) && fact_ok;
  assign len_room = (32'(len_q) < OPS_PER_FACT);
  assign slot_we  = (state == S_APP) && len_room;

  assign sweep_end = (state == S_SWEEP) && (32'(sweep_idx) == SWEEP_N - 1);

  always_comb begin
    len_we    = 1'b0;
    len_waddr = fid_r;
    len_wdata = len_q + LW'(1);
    if (state == S_SWEEP) begin
      len_we    = sweep_all && (32'(sweep_idx) < NUM_FACTS);
      len_waddr = FW'(sweep_idx);
      len_wdata = '0;
    end else if (slot_we) begin
      len_we = 1'b1;
    end
  end

  // walk pipeline: slot read, counter read, counter update
  assign slot_re   = (state == S_WALK) && (rd_i < len_r);
  assign o_ok      = (32'(slot_q) < NUM_OPERATORS);
  assign cnt_re    = (state == S_WALK) && a_v && o_ok;
  assign walk_done = (state == S_WALK) && (rd_i == len_r) && !a_v && !b_v;

  always_comb begin
    if (fwd_v && (fwd_op == b_op)) begin
      cur = fwd_cnt;
    end else if (rem_q[RW-1:CNT_W] == epoch) begin
      cur = rem_q[CNT_W-1:0];
    end else begin
      cur = pc_q;
    end
  end

  // every touch rewrites the tag, even when the counter already sits at zero
  assign touch   = (state == S_WALK) && b_v;
  assign dec     = touch && (cur != '0);
  assign res     = dec && (cur == CNT_W'(1));
  assign cnt_new = dec ? cur - CNT_W'(1) : cur;

  always_comb begin
    rem_we    = touch;
    rem_waddr = OW'(b_op);
    rem_wdata = {epoch, cnt_new};
    if (state == S_SWEEP) begin
      rem_we    = (32'(sweep_idx) < NUM_OPERATORS);
      rem_waddr = OW'(sweep_idx);
      rem_wdata = '0;
    end
  end

  // hold one result back so the last one of the item can be marked
  assign fifo_push      = pend_v && (res || walk_done);
  assign fifo_item.op   = pend_op;
  assign fifo_item.last = walk_done;
  assign fifo_pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (acc) begin
      act_append <= (action == ACT_APPEND);
      var_ok     <= (32'(variable) < NUM_VARIABLES);
      val_r      <= value;
      op_r       <= operator_index;
    end
    if (state == S_OFF) begin
      fid_r     <= fid;
      slot_base <= SW'(32'(fid) * OPS_PER_FACT);
    end
    if (state == S_LEN) begin
      len_r <= len_q;
    end
    b_op <= slot_q;
    if (touch) begin
      fwd_op  <= b_op;
      fwd_cnt <= cnt_new;
    end
    if (res) begin
      pend_op <= b_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_all <= 1'b1;
      sweep_idx <= '0;
      epoch     <= EPOCH_W'(1);
      ovf       <= 1'b0;
      rd_i      <= '0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      fwd_v     <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: begin
          if (sweep_end) begin
            sweep_idx <= '0;
            state     <= sweep_all ? S_IDLE : S_OFF;
            sweep_all <= 1'b0;
          end else begin
            sweep_idx <= sweep_idx + XW'(1);
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (action == ACT_APPEND && 32'(operator_index) < NUM_OPERATORS) begin
              state <= S_OFF;
            end else if (action == ACT_FACT) begin
              if (starts_state && epoch == EPOCH_MAX) begin
                // tags about to repeat: clear them first
                epoch <= EPOCH_W'(1);
                state <= S_SWEEP;
              end else begin
                state <= S_OFF;
                if (starts_state) begin
                  epoch <= epoch + EPOCH_W'(1);
                end
              end
            end
          end
        end
        S_OFF: begin
          if (!fact_ok) begin
            ovf   <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= act_append ? S_APP : S_LEN;
          end
        end
        S_APP: begin
          if (!len_room) begin
            ovf <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_LEN: begin
          rd_i  <= '0;
          a_v   <= 1'b0;
          b_v   <= 1'b0;
          fwd_v <= 1'b0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (slot_re) begin
            rd_i <= rd_i + LW'(1);
          end
          a_v   <= slot_re;
          b_v   <= a_v && o_ok;
          fwd_v <= touch;
          if (res) begin
            pend_v <= 1'b1;
          end else if (walk_done) begin
            pend_v <= 1'b0;
          end
          if (walk_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pcm_ram #(.DEPTH(NUM_VARIABLES), .WIDTH(10), .AW(VW)) u_offsets (
    .clk   (clk),
    .we    (off_we),
    .waddr (VW'(variable)),
    .wdata (number),
    .re    (acc),
    .raddr (VW'(variable)),
    .rdata (off_q)
  );

  pcm_ram #(.DEPTH(NUM_FACTS), .WIDTH(LW), .AW(FW)) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (fid),
    .rdata (len_q)
  );

  pcm_ram #(.DEPTH(SD), .WIDTH(OP_W), .AW(SW)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_base + SW'(len_q)),
    .wdata (op_r),
    .re    (slot_re),
    .raddr (slot_base + SW'(rd_i)),
    .rdata (slot_q)
  );

  pcm_ram #(.DEPTH(NUM_OPERATORS), .WIDTH(CNT_W), .AW(OW)) u_pcounts (
    .clk   (clk),
    .we    (pc_we),
    .waddr (OW'(operator_index)),
    .wdata (pc_wdata),
    .re    (cnt_re),
    .raddr (OW'(slot_q)),
    .rdata (pc_q)
  );

  pcm_ram #(.DEPTH(NUM_OPERATORS), .WIDTH(RW), .AW(OW)) u_remaining (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .re    (cnt_re),
    .raddr (OW'(slot_q)),
    .rdata (rem_q)
  );

  pcm_res_fifo #(.DEPTH(OPS_PER_FACT)) u_results (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_item (fifo_item),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  assign out_valid           = !fifo_empty;
  assign applicable_operator = fifo_head.op;
  assign last_of_run         = fifo_head.last;
  assign overflow_seen       = ovf;

  `PCM_ASSERT_SAME(a_ready_drained, in_ready, fifo_empty && !pend_v, "item taken with results pending")
  `PCM_ASSERT_SAME(a_push_room, fifo_push, !fifo_full, "result queue overrun")
  `PCM_ASSERT_SAME(a_epoch_live, dec, epoch != '0, "counter written with cleared tag")
  `PCM_ASSERT_NEXT(a_walk_ends, walk_done, state == S_IDLE && !pend_v, "walk did not retire")

endmodule
